// ----- rtl/core/khe_pkg.sv -----
// khe_pkg: shared types, codes and helper functions for the k-mer hash encoder.
// Used by kmer_hash_encoder, khe_datapath and khe_checker; depends on nothing.
`default_nettype none

package khe_pkg;

	localparam int MAX_K_DEFAULT = 16;
	localparam int SYMBOL_W      = 8;
	localparam int HASH_W        = 33;
	localparam int COUNT_W       = 5;
	localparam int STATUS_W      = 2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

	localparam logic [SYMBOL_W-1:0] CHAR_UC_A = 8'h41;
	localparam logic [SYMBOL_W-1:0] CHAR_UC_C = 8'h43;
	localparam logic [SYMBOL_W-1:0] CHAR_UC_G = 8'h47;
	localparam logic [SYMBOL_W-1:0] CHAR_UC_T = 8'h54;
	localparam logic [SYMBOL_W-1:0] CHAR_LC_A = 8'h61;
	localparam logic [SYMBOL_W-1:0] CHAR_LC_C = 8'h63;
	localparam logic [SYMBOL_W-1:0] CHAR_LC_G = 8'h67;
	localparam logic [SYMBOL_W-1:0] CHAR_LC_T = 8'h74;

	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic                last_symbol;
	} khe_in_t;

	typedef struct packed {
		logic [HASH_W-1:0]   forward_hash;
		logic [HASH_W-1:0]   revcomp_hash;
		logic [COUNT_W-1:0]  kmer_length;
		logic [STATUS_W-1:0] status;
	} khe_out_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] err;
	} khe_ctrl_t;

	// Offset (4^len - 4) / 3 = sum of 4^i for i in 1..len-1, kept to HASH_W bits.
	function automatic logic [HASH_W-1:0] length_offset(input logic [COUNT_W-1:0] len);
		logic [HASH_W-1:0] off;
		off = '0;
		for (int j = 2; j < HASH_W; j += 2) begin
			if (COUNT_W'(j / 2) < len) begin
				off[j] = 1'b1;
			end
		end
		return off;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/khe_datapath.sv -----
// khe_datapath: decodes one base and forms the next running codes and the result.
// Depends on khe_pkg; purely combinational, registers live in the top level.
`default_nettype none

module khe_datapath #(
	parameter int MAX_K  = khe_pkg::MAX_K_DEFAULT,
	parameter int CODE_W = (2 * MAX_K < khe_pkg::HASH_W) ? 2 * MAX_K : khe_pkg::HASH_W
) (
	input  wire logic [CODE_W-1:0]                 fwd_cur,
	input  wire logic [CODE_W-1:0]                 rev_cur,
	input  wire khe_pkg::khe_ctrl_t                ctrl_cur,
	input  wire logic [khe_pkg::SYMBOL_W-1:0]      symbol,
	output logic      [CODE_W-1:0]                 fwd_next,
	output logic      [CODE_W-1:0]                 rev_next,
	output khe_pkg::khe_ctrl_t                     ctrl_next,
	output khe_pkg::khe_out_t                      result
);
	import khe_pkg::*;

	logic       base_ok;
	logic [1:0] base;
	logic [1:0] comp;
	logic       full;
	logic [HASH_W-1:0] offset;

	always_comb begin
		base_ok = 1'b1;
		base    = BASE_A;
		case (symbol)
			CHAR_UC_A, CHAR_LC_A: base = BASE_A;
			CHAR_UC_C, CHAR_LC_C: base = BASE_C;
			CHAR_UC_G, CHAR_LC_G: base = BASE_G;
			CHAR_UC_T, CHAR_LC_T: base = BASE_T;
			default: base_ok = 1'b0;
		endcase
	end

	assign comp = BASE_T - base;
	assign full = (ctrl_cur.count >= COUNT_W'(MAX_K));

	always_comb begin
		fwd_next  = fwd_cur;
		rev_next  = rev_cur;
		ctrl_next = ctrl_cur;
		if (full) begin
			if (ctrl_cur.err == ST_OK) begin
				ctrl_next.err = ST_TOO_LONG;
			end
		end else begin
			if (!base_ok) begin
				ctrl_next.err = ST_BAD_CHAR;
			end else begin
				fwd_next = (fwd_cur << 2) | CODE_W'(base);
				// drop the complement into the pair selected by the count
				for (int j = 0; j < CODE_W; j++) begin
					if (ctrl_cur.count == COUNT_W'(j / 2)) begin
						rev_next[j] = rev_cur[j] | comp[j % 2];
					end
				end
			end
			ctrl_next.count = ctrl_cur.count + COUNT_W'(1);
		end
	end

	assign offset = length_offset(ctrl_next.count);

	always_comb begin
		result.kmer_length = ctrl_next.count;
		result.status      = ctrl_next.err;
		if (ctrl_next.err != ST_OK) begin
			result.forward_hash = '0;
			result.revcomp_hash = '0;
		end else begin
			result.forward_hash = HASH_W'(fwd_next) + offset;
			result.revcomp_hash = HASH_W'(rev_next) + offset;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/kmer_hash_encoder.sv -----
// kmer_hash_encoder: top level of the two-bit k-mer hash encoder.
// Depends on khe_pkg and khe_datapath.
//
// Usage:
//   The sym channel carries one ASCII base per transaction (A, C, G, T in either
//   case) with last_symbol marking the final base of a k-mer. Only a transaction
//   with last_symbol set produces a hash transaction; all others just update the
//   running forward and reverse-complement codes.
//   The hash channel returns forward_hash, revcomp_hash (both length-offset by
//   (4^L-4)/3), kmer_length and status. A bad character or a k-mer longer than
//   MAX_K gives zero hashes and a nonzero status; state clears after every result.
// Path: the input register, then the result register that drives the hash channel.
// Throughput: one base per cycle while no last base is stalled, set by the update of
//   the running code registers between the input register and the result register.
// Stall: while a result waits, bases without the last mark keep flowing; the next
//   last base holds in the input register until the waiting result is taken.
// Reset: arst_n clears both valid flags and all running state; no clearing pass.
`default_nettype none

module kmer_hash_encoder #(
	parameter int MAX_K = khe_pkg::MAX_K_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sym_valid,
	output logic                   sym_ready,
	input  wire khe_pkg::khe_in_t  sym,
	output logic                   hash_valid,
	input  wire logic              hash_ready,
	output khe_pkg::khe_out_t      hash
);
	import khe_pkg::*;

	localparam int CODE_W = (2 * MAX_K < HASH_W) ? 2 * MAX_K : HASH_W;

	// input register
	logic      valid_s1;
	khe_in_t   sym_s1;

	// running k-mer state
	logic [CODE_W-1:0] fwd_q;
	logic [CODE_W-1:0] rev_q;
	khe_ctrl_t         ctrl_q;

	// result register
	logic      out_valid_q;
	khe_out_t  out_q;

	logic [CODE_W-1:0] fwd_d;
	logic [CODE_W-1:0] rev_d;
	khe_ctrl_t         ctrl_d;
	khe_out_t          result_d;
	logic              advance;

	khe_datapath #(
		.MAX_K  (MAX_K),
		.CODE_W (CODE_W)
	) u_datapath (
		.fwd_cur   (fwd_q),
		.rev_cur   (rev_q),
		.ctrl_cur  (ctrl_q),
		.symbol    (sym_s1.symbol),
		.fwd_next  (fwd_d),
		.rev_next  (rev_d),
		.ctrl_next (ctrl_d),
		.result    (result_d)
	);

	// A last base may only retire when the result register is free or draining.
	assign advance   = valid_s1 && (!sym_s1.last_symbol || !out_valid_q || hash_ready);
	assign sym_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sym_ready) begin
			valid_s1 <= sym_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sym_ready && sym_valid) begin
			sym_s1 <= sym;
		end
	end

	// Advance running state; clear it once the k-mer closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q  <= '0;
			rev_q  <= '0;
			ctrl_q <= '0;
		end else if (advance) begin
			if (sym_s1.last_symbol) begin
				fwd_q  <= '0;
				rev_q  <= '0;
				ctrl_q <= '0;
			end else begin
				fwd_q  <= fwd_d;
				rev_q  <= rev_d;
				ctrl_q <= ctrl_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && sym_s1.last_symbol) begin
			out_valid_q <= 1'b1;
		end else if (hash_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && sym_s1.last_symbol) begin
			out_q <= result_d;
		end
	end

	assign hash_valid = out_valid_q;
	assign hash       = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/khe_checker.sv -----
// khe_checker: port-level assertions for kmer_hash_encoder, bound to the top level.
// Depends on khe_pkg and on the port names of kmer_hash_encoder.
`default_nettype none

module khe_checker #(
	parameter int MAX_K = khe_pkg::MAX_K_DEFAULT
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              sym_valid,
	input wire logic              sym_ready,
	input wire khe_pkg::khe_in_t  sym,
	input wire logic              hash_valid,
	input wire logic              hash_ready,
	input wire khe_pkg::khe_out_t hash
);
	import khe_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && !hash_ready |=> hash_valid && $stable(hash))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && hash.status != ST_OK |->
			hash.forward_hash == '0 && hash.revcomp_hash == '0)
		else $error("nonzero hash on error result");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid |-> hash.kmer_length <= COUNT_W'(MAX_K) && hash.kmer_length != '0)
		else $error("k-mer length out of range");

	a_too_long: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && hash.status == ST_TOO_LONG |-> hash.kmer_length == COUNT_W'(MAX_K))
		else $error("length error without saturated count");

	// sym inputs are observed but not constrained here
	logic unused_in;
	assign unused_in = sym_valid ^ sym_ready ^ (^sym);

endmodule

bind kmer_hash_encoder khe_checker #(.MAX_K(MAX_K)) u_khe_checker (.*);

`default_nettype wire
